>>> hdl/lzss_ring_decoder_macros.svh
// assertion macros for the lzss ring decoder
`ifndef LZSS_RING_DECODER_MACROS_SVH
`define LZSS_RING_DECODER_MACROS_SVH

// same-cycle implication
`define LZSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzss_ring_decoder: assertion failed");

// next-cycle implication
`define LZSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzss_ring_decoder: assertion failed");

`endif

>>> hdl/lzss_pkg.sv
// shared types and constants of the lzss ring decoder
package lzss_pkg;

    localparam int unsigned RING_AW    = 12;
    localparam int unsigned RING_DEPTH = 1 << RING_AW;
    localparam int unsigned START_IDX  = 4078;
    localparam int unsigned TOP_SPAN   = RING_DEPTH - START_IDX;
    localparam int unsigned TOP_IW     = $clog2(TOP_SPAN);

    typedef logic [RING_AW-1:0] ring_addr_t;
    typedef logic [7:0]         byte_t;
    typedef logic [RING_AW:0]   fill_cnt_t;
    typedef logic [3:0]         bit_pos_t;
    typedef logic [4:0]         copy_len_t;

    localparam ring_addr_t START_POS   = ring_addr_t'(START_IDX);
    localparam byte_t      FILL_CHAR   = 8'h20;
    localparam bit_pos_t   FLAG_NEEDED = 4'd8;
    localparam copy_len_t  MIN_MATCH   = 5'd3;

    typedef struct packed {
        logic       en;
        ring_addr_t addr;
        byte_t      data;
    } hist_wr_t;

    typedef struct packed {
        logic       en;
        ring_addr_t addr;
    } hist_rd_t;

endpackage

>>> hdl/lzss_if.sv
// valid/ready channel interfaces for compressed and decoded bytes
interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_stream;
    logic       last_of_stream;

    modport source (output valid, output in_byte, output first_of_stream,
                    output last_of_stream, input ready);
    modport sink (input valid, input in_byte, input first_of_stream,
                  input last_of_stream, output ready);
endinterface

interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> hdl/lzss_hist.sv
// history ring: 4096-byte memory with fill tracking and write-to-read bypass
module lzss_hist (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             restart,
    input  lzss_pkg::hist_wr_t wr,
    input  lzss_pkg::hist_rd_t rd,
    output lzss_pkg::byte_t  rd_data
);
    import lzss_pkg::*;

    byte_t               mem [RING_DEPTH];
    byte_t               mem_q_reg;
    logic                byp_reg;
    byte_t               byp_data_reg;
    logic                blank_reg;
    byte_t               blank_val_reg;
    fill_cnt_t           fill_reg;
    fill_cnt_t           fill_next;
    logic [TOP_SPAN-1:0] top_valid_reg;
    logic [TOP_SPAN-1:0] top_valid_next;

    ring_addr_t          rd_rel;
    ring_addr_t          wr_rel;
    logic                rd_top;
    logic                wr_top;
    logic                rd_fresh;
    logic                rd_blank;
    logic                rd_byp;

    // positions written since restart form one run starting at the start position
    assign rd_rel   = rd.addr - START_POS;
    assign wr_rel   = wr.addr - START_POS;
    assign rd_top   = rd.addr >= START_POS;
    assign wr_top   = wr.addr >= START_POS;
    assign rd_fresh = {1'b0, rd_rel} < fill_reg;
    assign rd_blank = !rd_fresh && (!rd_top || !top_valid_reg[rd_rel[TOP_IW-1:0]]);
    assign rd_byp   = wr.en && (wr.addr == rd.addr);

    always_comb
    begin
        fill_next      = fill_reg;
        top_valid_next = top_valid_reg;
        if (restart)
        begin
            fill_next = '0;
        end
        else if (wr.en && (fill_reg != fill_cnt_t'(RING_DEPTH)))
        begin
            fill_next = fill_reg + fill_cnt_t'(1);
        end
        if (wr.en && wr_top)
        begin
            top_valid_next[wr_rel[TOP_IW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            top_valid_reg <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            top_valid_reg <= top_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            mem_q_reg     <= mem[rd.addr];
            byp_reg       <= rd_byp;
            byp_data_reg  <= wr.data;
            blank_reg     <= rd_blank;
            blank_val_reg <= rd_top ? 8'h00 : FILL_CHAR;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : (blank_reg ? blank_val_reg : mem_q_reg);

endmodule

>>> hdl/lzss_ring_decoder.sv
// lzss ring decoder top level: byte sequencer driving the history ring copy unit
// literal: result registered in the cycle after the transaction; flag and first pair byte: no result
// pair: ready low while the copy runs, until the last copied byte is emitted (3..18 bytes)
// copies: ring read register and s2, then output register; overlapping copies use a bypass
// reset: ring reads as spaces below 4078 and zero above, write position 4078, flag expected
// no clearing pass: a fill count and 18 valid bits stand in for the cleared contents
module lzss_ring_decoder (
    input  logic       clk,
    input  logic       rst_n,
    lzss_in_if.sink    compressed,
    lzss_out_if.source decoded
);
    import lzss_pkg::*;
    `include "lzss_ring_decoder_macros.svh"

    typedef enum logic {ST_IDLE, ST_COPY} state_t;

    state_t     state_reg, state_next;
    byte_t      flag_bits_reg, flag_bits_next;
    bit_pos_t   bit_pos_reg, bit_pos_next;
    byte_t      pair_low_reg, pair_low_next;
    logic       pair_pending_reg, pair_pending_next;
    ring_addr_t wp_reg, wp_next;
    ring_addr_t rd_addr_reg, rd_addr_next;
    copy_len_t  rd_cnt_reg, rd_cnt_next;
    copy_len_t  len_reg, len_next;
    logic       s2_valid_reg, s2_valid_next;
    logic       s2_last_reg, s2_last_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    hist_wr_t   wr;
    hist_rd_t   rd;
    byte_t      rd_data;
    logic       restart;
    logic       adv;
    logic       accept;
    logic       pend_eff;
    bit_pos_t   bit_eff;
    byte_t      flag_eff;
    ring_addr_t wp_eff;

    lzss_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign adv              = !out_valid_reg || decoded.ready;
    assign compressed.ready = (state_reg == ST_IDLE) && adv;
    assign accept           = compressed.valid && compressed.ready;

    assign pend_eff = compressed.first_of_stream ? 1'b0 : pair_pending_reg;
    assign bit_eff  = compressed.first_of_stream ? FLAG_NEEDED : bit_pos_reg;
    assign flag_eff = compressed.first_of_stream ? 8'h00 : flag_bits_reg;
    assign wp_eff   = compressed.first_of_stream ? START_POS : wp_reg;

    always_comb
    begin
        state_next        = state_reg;
        flag_bits_next    = flag_bits_reg;
        bit_pos_next      = bit_pos_reg;
        pair_low_next     = pair_low_reg;
        pair_pending_next = pair_pending_reg;
        wp_next           = wp_reg;
        rd_addr_next      = rd_addr_reg;
        rd_cnt_next       = rd_cnt_reg;
        len_next          = len_reg;
        s2_valid_next     = s2_valid_reg;
        s2_last_next      = s2_last_reg;
        out_valid_next    = out_valid_reg;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        wr                = '0;
        rd                = '0;
        restart           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b0;
                end
                if (accept)
                begin
                    restart           = compressed.first_of_stream;
                    wp_next           = wp_eff;
                    bit_pos_next      = bit_eff;
                    pair_pending_next = pend_eff;
                    flag_bits_next    = flag_eff;
                    if (compressed.first_of_stream)
                    begin
                        pair_low_next = 8'h00;
                    end
                    if (pend_eff)
                    begin
                        rd_addr_next      = {compressed.in_byte[7:4], pair_low_reg};
                        len_next          = {1'b0, compressed.in_byte[3:0]} + MIN_MATCH;
                        rd_cnt_next       = '0;
                        s2_valid_next     = 1'b0;
                        pair_pending_next = 1'b0;
                        bit_pos_next      = bit_eff + bit_pos_t'(1);
                        state_next        = ST_COPY;
                    end
                    else if (bit_eff >= FLAG_NEEDED)
                    begin
                        flag_bits_next = compressed.in_byte;
                        bit_pos_next   = '0;
                    end
                    else if (flag_eff[bit_eff[2:0]])
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = compressed.in_byte;
                        out_last_next  = 1'b1;
                        wr.en          = 1'b1;
                        wr.addr        = wp_eff;
                        wr.data        = compressed.in_byte;
                        wp_next        = wp_eff + ring_addr_t'(1);
                        bit_pos_next   = bit_eff + bit_pos_t'(1);
                    end
                    else
                    begin
                        pair_low_next     = compressed.in_byte;
                        pair_pending_next = 1'b1;
                    end
                    if (compressed.last_of_stream)
                    begin
                        pair_pending_next = 1'b0;
                        bit_pos_next      = FLAG_NEEDED;
                    end
                end
            end
            ST_COPY:
            begin
                if (adv)
                begin
                    // read stage
                    rd.en   = rd_cnt_reg < len_reg;
                    rd.addr = rd_addr_reg;
                    if (rd.en)
                    begin
                        rd_addr_next = rd_addr_reg + ring_addr_t'(1);
                        rd_cnt_next  = rd_cnt_reg + copy_len_t'(1);
                    end
                    s2_valid_next = rd.en;
                    s2_last_next  = rd_cnt_reg == (len_reg - copy_len_t'(1));
                    // emit and write-back stage
                    out_valid_next = s2_valid_reg;
                    if (s2_valid_reg)
                    begin
                        out_byte_next = rd_data;
                        out_last_next = s2_last_reg;
                        wr.en         = 1'b1;
                        wr.addr       = wp_reg;
                        wr.data       = rd_data;
                        wp_next       = wp_reg + ring_addr_t'(1);
                        if (s2_last_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            flag_bits_reg    <= '0;
            bit_pos_reg      <= FLAG_NEEDED;
            pair_low_reg     <= '0;
            pair_pending_reg <= 1'b0;
            wp_reg           <= START_POS;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            flag_bits_reg    <= flag_bits_next;
            bit_pos_reg      <= bit_pos_next;
            pair_low_reg     <= pair_low_next;
            pair_pending_reg <= pair_pending_next;
            wp_reg           <= wp_next;
            s2_valid_reg     <= s2_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        rd_cnt_reg   <= rd_cnt_next;
        len_reg      <= len_next;
        s2_last_reg  <= s2_last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign decoded.valid       = out_valid_reg;
    assign decoded.out_byte    = out_byte_reg;
    assign decoded.last_of_run = out_last_reg;

    `LZSS_ASSERT_NOW(a_s2_only_in_copy, s2_valid_reg, state_reg == ST_COPY)
    `LZSS_ASSERT_NOW(a_rd_cnt_bound, state_reg == ST_COPY, rd_cnt_reg <= len_reg)
    `LZSS_ASSERT_NEXT(a_copy_ends, s2_valid_reg && s2_last_reg && adv, state_reg == ST_IDLE)
    `LZSS_ASSERT_NOW(a_bit_pos_range, 1'b1, bit_pos_reg <= FLAG_NEEDED)

endmodule

>>> tb/lzss_decode_checker.sv
// decoded byte checker: tracks the compressed stream, predicts decoded bytes and compares them
module lzss_decode_checker
(
    input  logic clk,
    input  logic rst_n,
    lzss_in_if   compressed,
    lzss_out_if  decoded,
    output int   errors,
    output int   pending
);
    import lzss_pkg::*;

    typedef struct packed
    {
        byte_t data;
        logic  last;
    } decoded_t;

    byte_t      ring [RING_DEPTH];
    ring_addr_t wr_pos;
    byte_t      flags;
    bit_pos_t   flag_idx;
    byte_t      offset_low;
    logic       half_pair;
    decoded_t   expected_bytes [$];

    function automatic void restart_stream();
        for (int i = 0; i < START_IDX; i++)
        begin
            ring[i] = FILL_CHAR;
        end
        wr_pos     = START_POS;
        flags      = '0;
        flag_idx   = FLAG_NEEDED;
        offset_low = '0;
        half_pair  = 1'b0;
    endfunction

    function automatic void put_byte(input byte_t data, input logic last);
        expected_bytes.push_back('{data, last});
        ring[wr_pos] = data;
        wr_pos       = wr_pos + 1'b1;
    endfunction

    function automatic void decode_input(input byte_t data, input logic first, input logic last);
        ring_addr_t src;
        copy_len_t  len;
        if (first)
        begin
            restart_stream();
        end
        if (half_pair)
        begin
            src = {data[7:4], offset_low};
            len = copy_len_t'(data[3:0]) + MIN_MATCH;
            for (int k = 0; k < int'(len); k++)
            begin
                put_byte(ring[src], k == int'(len) - 1);
                src = src + 1'b1;
            end
            half_pair = 1'b0;
            flag_idx  = flag_idx + 1'b1;
        end
        else if (flag_idx >= FLAG_NEEDED)
        begin
            flags    = data;
            flag_idx = '0;
        end
        else if (flags[flag_idx[2:0]])
        begin
            put_byte(data, 1'b1);
            flag_idx = flag_idx + 1'b1;
        end
        else
        begin
            offset_low = data;
            half_pair  = 1'b1;
        end
        if (last)
        begin
            half_pair = 1'b0;
            flag_idx  = FLAG_NEEDED;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        decoded_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring[i] = '0;
            end
            restart_stream();
            expected_bytes.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (compressed.valid && compressed.ready)
            begin
                decode_input(compressed.in_byte, compressed.first_of_stream,
                             compressed.last_of_stream);
            end
            if (decoded.valid && decoded.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, got out_byte %h last %b",
                             $time, decoded.out_byte, decoded.last_of_run);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (decoded.out_byte !== want.data)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %h got %h",
                                 $time, want.data, decoded.out_byte);
                    end
                    if (decoded.last_of_run !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_of_run expected %b got %b",
                                 $time, want.last, decoded.last_of_run);
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

>>> tb/testbench.sv
// testbench top: clock, reset, compressed byte streams under varied idling and output stalls, and the verdict
module testbench;
    import lzss_pkg::*;

    typedef struct packed
    {
        byte_t data;
        logic  first;
        logic  last;
    } comp_byte_t;

    logic       clk;
    logic       rst_n;
    int         errors;
    int         pending;
    int         sent_count = 0;
    int         idle_pct   = 0;
    int         stall_pct  = 0;
    ring_addr_t gen_pos    = START_POS;

    lzss_in_if  compressed ();
    lzss_out_if decoded ();

    lzss_ring_decoder u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .compressed (compressed),
        .decoded    (decoded)
    );

    lzss_decode_checker u_decode_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .compressed (compressed),
        .decoded    (decoded),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        decoded.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_byte(input byte_t data, input logic first, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            compressed.valid <= 1'b0;
            @(posedge clk);
        end
        compressed.valid           <= 1'b1;
        compressed.in_byte         <= data;
        compressed.first_of_stream <= first;
        compressed.last_of_stream  <= last;
        do @(posedge clk); while (!compressed.ready);
        sent_count++;
    endtask

    task automatic send_stream();
        comp_byte_t seq [$];
        comp_byte_t tail;
        byte_t      flag;
        byte_t      high;
        ring_addr_t src;
        logic       first;
        int         cut;
        if ($urandom_range(7) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                send_byte(byte_t'($urandom), $urandom_range(3) == 0, $urandom_range(3) == 0);
            end
            return;
        end
        first = ($urandom_range(3) != 0);
        if (first)
        begin
            gen_pos = START_POS;
        end
        repeat ($urandom_range(1, 3))
        begin
            flag = byte_t'($urandom);
            seq.push_back('{flag, first && seq.size() == 0, 1'b0});
            for (int i = 0; i < 8; i++)
            begin
                if (flag[i])
                begin
                    seq.push_back('{byte_t'($urandom), 1'b0, 1'b0});
                    gen_pos = gen_pos + 1'b1;
                end
                else
                begin
                    case ($urandom_range(3))
                        0:       src = gen_pos - ring_addr_t'($urandom_range(1, 18));
                        1:       src = ring_addr_t'($urandom_range(START_IDX - 20, RING_DEPTH - 1));
                        2:       src = ring_addr_t'($urandom_range(0, 40));
                        default: src = ring_addr_t'($urandom);
                    endcase
                    high = {src[11:8], 4'($urandom)};
                    seq.push_back('{src[7:0], 1'b0, 1'b0});
                    seq.push_back('{high, 1'b0, 1'b0});
                    gen_pos = gen_pos + ring_addr_t'(high[3:0]) + ring_addr_t'(MIN_MATCH);
                end
            end
        end
        if ($urandom_range(5) == 0)
        begin
            cut = $urandom_range(1, seq.size());
            while (seq.size() > cut)
            begin
                void'(seq.pop_back());
            end
        end
        if ($urandom_range(4) != 0)
        begin
            tail      = seq.pop_back();
            tail.last = 1'b1;
            seq.push_back(tail);
        end
        foreach (seq[i])
        begin
            send_byte(seq[i].data, seq[i].first, seq[i].last);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        int stop_at;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = sent_count + count;
        while (sent_count < stop_at)
        begin
            send_stream();
        end
    endtask

    initial
    begin
        rst_n                      = 1'b0;
        compressed.valid           = 1'b0;
        compressed.in_byte         = '0;
        compressed.first_of_stream = 1'b0;
        compressed.last_of_stream  = 1'b0;
        decoded.ready              = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full group: literals and pairs, far wrap, preset top region
        send_byte(8'hA5, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hEE, 1'b0, 1'b0);
        send_byte(8'hF0, 1'b0, 1'b0);
        send_byte(8'h04, 1'b0, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h81, 1'b0, 1'b0);
        // a flag byte and a half pair cut at stream end, then a new group without restart
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h12, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        // restart while a pair is half received
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h10, 1'b0, 1'b0);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h77, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);

        run_phase(0, 0, 65);
        run_phase(75, 0, 65);
        run_phase(0, 75, 65);
        run_phase(31, 31, 65);

        compressed.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("%0t: timeout with %0d decoded bytes outstanding", $time, pending);
        $display("status: fail");
        $finish;
    end

endmodule
